// File: rtl/radius_attribute_walker_top_macros.svh
// Assertion macros shared by the attribute walker RTL.
`ifndef RADIUS_ATTRIBUTE_WALKER_TOP_MACROS_SVH
`define RADIUS_ATTRIBUTE_WALKER_TOP_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define RAW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset.
`define RAW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/raw_pkg.sv
// Package: constants, codes and types of the attribute walker.
`default_nettype none

package raw_pkg;

    localparam int HEADER_BYTES     = 20;
    localparam int VSA_HEADER_BYTES = 8;

    localparam logic [7:0]  VENDOR_SPECIFIC  = 8'd26;
    localparam logic [15:0] LEN_HI_POS       = 16'd2;
    localparam logic [15:0] LEN_LO_POS       = 16'd3;
    localparam logic [15:0] HDR_LAST_POS     = 16'(HEADER_BYTES - 1);
    localparam logic [15:0] HDR_LEN          = 16'(HEADER_BYTES);
    localparam logic [7:0]  VSA_MIN_LEN      = 8'(VSA_HEADER_BYTES);
    localparam logic [15:0] VSA_INNER_OFFSET = 16'd6;
    localparam logic [7:0]  ATTR_MIN_LEN     = 8'd2;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_ATTR
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_SHORT_HEADER,
        ST_OVERRUN,
        ST_ATTR_SHORT,
        ST_VSA_SHORT,
        ST_VSA_MISMATCH
    } status_t;

    typedef struct packed {
        logic [7:0]  attr_type;
        logic [31:0] vendor_id;
        logic [15:0] attr_offset;
        logic [7:0]  attr_length;
        logic        attr_valid;
        logic        packet_done;
        status_t     status;
    } res_t;

endpackage

`default_nettype wire

// File: rtl/raw_walk.sv
// Walk state and per-byte decode: header length, attribute and vendor fields.
`default_nettype none

module raw_walk (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               in_take,
    input  wire  [7:0]        in_byte,
    input  wire               in_start,
    output logic              res_valid,
    output raw_pkg::res_t     res
);

    raw_pkg::phase_t phase_reg, phase_next, phase_e;

    logic [15:0] pos_reg, pos_next, pos_e;
    logic [15:0] len_reg, len_next, len_e;
    logic [15:0] rem_reg, rem_next, rem_e;
    logic [15:0] astart_reg, astart_next, astart_e;
    logic [7:0]  type_reg, type_next, type_e;
    logic [7:0]  alen_reg, alen_next, alen_e;
    logic [7:0]  idx_reg, idx_next, idx_e;
    logic [31:0] vendor_reg, vendor_next, vendor_e;
    logic [7:0]  itype_reg, itype_next, itype_e;
    logic [7:0]  ilen_reg, ilen_next, ilen_e;

    logic go_idle, go_attr, cmp_ev, fail_ev, vsa;
    raw_pkg::status_t fail_st;
    logic [15:0] fail_off;

    // Datapath: effective state (start restarts the walk) and per-byte update
    always_comb begin
        if (in_start) begin
            phase_e  = raw_pkg::PH_HEADER;
            pos_e    = '0;
            len_e    = '0;
            rem_e    = '0;
            astart_e = '0;
            type_e   = '0;
            alen_e   = '0;
            idx_e    = '0;
            vendor_e = '0;
            itype_e  = '0;
            ilen_e   = '0;
        end else begin
            phase_e  = phase_reg;
            pos_e    = pos_reg;
            len_e    = len_reg;
            rem_e    = rem_reg;
            astart_e = astart_reg;
            type_e   = type_reg;
            alen_e   = alen_reg;
            idx_e    = idx_reg;
            vendor_e = vendor_reg;
            itype_e  = itype_reg;
            ilen_e   = ilen_reg;
        end

        pos_next    = pos_e;
        len_next    = len_e;
        rem_next    = rem_e;
        astart_next = astart_e;
        type_next   = type_e;
        alen_next   = alen_e;
        idx_next    = idx_e;
        vendor_next = vendor_e;
        itype_next  = itype_e;
        ilen_next   = ilen_e;

        go_idle   = 1'b0;
        go_attr   = 1'b0;
        cmp_ev    = 1'b0;
        fail_ev   = 1'b0;
        fail_st   = raw_pkg::ST_OK;
        fail_off  = astart_e;
        res       = '0;
        res_valid = 1'b0;
        vsa       = (type_e == raw_pkg::VENDOR_SPECIFIC);

        case (phase_e)
            raw_pkg::PH_HEADER: begin
                pos_next = pos_e + 16'd1;
                if (pos_e == raw_pkg::LEN_HI_POS) begin
                    len_next = {in_byte, 8'h00};
                end else if (pos_e == raw_pkg::LEN_LO_POS) begin
                    len_next = len_e | {8'h00, in_byte};
                    if (len_next < raw_pkg::HDR_LEN) begin
                        fail_ev  = 1'b1;
                        fail_st  = raw_pkg::ST_SHORT_HEADER;
                        fail_off = '0;
                    end
                end else if (pos_e == raw_pkg::HDR_LAST_POS) begin
                    rem_next = len_e - raw_pkg::HDR_LEN;
                    if (rem_next < 16'd2) begin
                        go_idle           = 1'b1;
                        res_valid         = 1'b1;
                        res.packet_done   = 1'b1;
                    end else begin
                        go_attr  = 1'b1;
                        idx_next = '0;
                    end
                end
            end
            raw_pkg::PH_ATTR: begin
                pos_next = pos_e + 16'd1;
                if (idx_e == 8'd0) begin
                    astart_next = pos_e;
                    type_next   = in_byte;
                    vendor_next = '0;
                    idx_next    = 8'd1;
                end else if (idx_e == 8'd1) begin
                    if ({8'h00, in_byte} > rem_e) begin
                        fail_ev = 1'b1;
                        fail_st = raw_pkg::ST_OVERRUN;
                    end else if (in_byte < raw_pkg::ATTR_MIN_LEN) begin
                        fail_ev = 1'b1;
                        fail_st = raw_pkg::ST_ATTR_SHORT;
                    end else if (vsa && in_byte < raw_pkg::VSA_MIN_LEN) begin
                        fail_ev = 1'b1;
                        fail_st = raw_pkg::ST_VSA_SHORT;
                    end else begin
                        rem_next  = rem_e - {8'h00, in_byte};
                        alen_next = in_byte;
                        idx_next  = 8'd2;
                        cmp_ev    = !vsa && (in_byte == raw_pkg::ATTR_MIN_LEN);
                    end
                end else begin
                    if (vsa && idx_e >= 8'd2 && idx_e <= 8'd5) begin
                        vendor_next = {vendor_e[23:0], in_byte};
                    end else if (vsa && idx_e == 8'd6) begin
                        itype_next = in_byte;
                    end else if (vsa && idx_e == 8'd7) begin
                        ilen_next = in_byte;
                        if ({1'b0, in_byte} + 9'(raw_pkg::VSA_HEADER_BYTES)
                                != {1'b0, alen_e} + 9'd2) begin
                            fail_ev = 1'b1;
                            fail_st = raw_pkg::ST_VSA_MISMATCH;
                        end
                    end
                    if (!fail_ev) begin
                        if ({1'b0, idx_e} + 9'd1 >= {1'b0, alen_e}) begin
                            cmp_ev = 1'b1;
                        end else begin
                            idx_next = idx_e + 8'd1;
                        end
                    end
                end
            end
            default: ;
        endcase

        if (fail_ev) begin
            go_idle         = 1'b1;
            res_valid       = 1'b1;
            res             = '0;
            res.attr_offset = fail_off;
            res.packet_done = 1'b1;
            res.status      = fail_st;
        end else if (cmp_ev) begin
            res_valid       = 1'b1;
            res.attr_valid  = 1'b1;
            res.packet_done = (rem_next < 16'd2);
            res.status      = raw_pkg::ST_OK;
            if (vsa) begin
                res.attr_type   = itype_next;
                res.vendor_id   = vendor_next;
                res.attr_offset = astart_e + raw_pkg::VSA_INNER_OFFSET;
                res.attr_length = ilen_next;
            end else begin
                res.attr_type   = type_e;
                res.vendor_id   = '0;
                res.attr_offset = astart_e;
                res.attr_length = alen_next;
            end
            idx_next    = '0;
            vendor_next = '0;
            itype_next  = '0;
            ilen_next   = '0;
            go_idle     = res.packet_done;
        end

        res_valid = res_valid && in_take;
    end

    // Next walk phase
    always_comb begin
        if (!in_take) begin
            phase_next = phase_reg;
        end else if (go_idle) begin
            phase_next = raw_pkg::PH_IDLE;
        end else if (go_attr) begin
            phase_next = raw_pkg::PH_ATTR;
        end else begin
            phase_next = phase_e;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= raw_pkg::PH_IDLE;
        end else begin
            phase_reg <= phase_next;
        end
    end

    // Walk registers are all reloaded by a start byte before use
    always_ff @(posedge aclk) begin
        if (in_take) begin
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            rem_reg    <= rem_next;
            astart_reg <= astart_next;
            type_reg   <= type_next;
            alen_reg   <= alen_next;
            idx_reg    <= idx_next;
            vendor_reg <= vendor_next;
            itype_reg  <= itype_next;
            ilen_reg   <= ilen_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/radius_attribute_walker_top.sv
// Top level: byte stream in, attribute report stream out, two-slot result buffer.
//
// Usage:
//  - s_ side takes one packet byte per item; s_tuser marks the first header
//    byte of a packet. A start byte mid-walk drops the old walk silently.
//  - m_ side gives one report per finished attribute, per error, or per
//    packet with an empty body. m_tlast is set on the report that ends the
//    walk; m_tuser carries the attribute-valid flag and the status code.
//  - Bytes outside a walk (after its end or before a start) give no report.
//  - Throughput: one byte per cycle while s_tready is high, set by the
//    combinational decode between the walk registers and the result register.
//  - Output: a report is registered into the output register, or into the
//    skid slot when that is full, as the byte that completes it is accepted.
//  - Stall: results go to an output register backed by one skid slot, so
//    bytes keep flowing while one result waits; s_tready drops only when
//    both slots hold results.
//  - Reset (aresetn low, synchronous): walk goes idle, both slots empty.
`default_nettype none
`include "radius_attribute_walker_top_macros.svh"

module radius_attribute_walker_top (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] packet_byte
    input  wire  [0:0]  s_tuser,   // [0] packet_start
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [63:0] m_tdata,   // [7:0] attr_type, [39:8] vendor_id,
                                   // [55:40] attr_offset, [63:56] attr_length
    output logic        m_tlast,   // packet_done
    output logic [3:0]  m_tuser    // [0] attr_valid, [3:1] status
);

    logic          take;
    logic          res_valid;
    raw_pkg::res_t res;

    raw_pkg::res_t out_reg, skid_reg;
    logic          out_valid_reg, skid_valid_reg;
    logic          pop;

    assign s_tready = !skid_valid_reg;
    assign take     = s_tvalid && s_tready;
    assign pop      = out_valid_reg && m_tready;

    raw_walk u_walk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_take   (take),
        .in_byte   (s_tdata),
        .in_start  (s_tuser[0]),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (res_valid) begin
            if (!out_valid_reg || pop) begin
                out_reg       <= res;
                out_valid_reg <= 1'b1;
            end else begin
                skid_reg       <= res;
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.attr_length, out_reg.attr_offset,
                       out_reg.vendor_id, out_reg.attr_type};
    assign m_tlast  = out_reg.packet_done;
    assign m_tuser  = {out_reg.status, out_reg.attr_valid};

    `RAW_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid slot full while output empty")
    `RAW_ASSERT_NEXT(a_skid_held, skid_valid_reg && !m_tready, skid_valid_reg, "skid item lost while stalled")
    `RAW_ASSERT_NOW(a_error_ends_walk, m_tvalid && m_tuser[3:1] != raw_pkg::ST_OK, !m_tuser[0] && m_tlast, "error report not ending the walk")

endmodule

`default_nettype wire

// File: dv/tb_radius_attribute_walker_top.sv
// Testbench for the RADIUS attribute walker: directed table, then random packets checked by a predictor.
`timescale 1ns / 1ps

module tb_radius_attribute_walker_top;

    localparam int RAND_ITEMS  = 1300;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AT     = 600;
    localparam int TAIL_CYCLES = 16;

    typedef struct {
        logic [7:0]    pbyte;
        logic          pstart;
        bit            typed;
        raw_pkg::res_t res;
    } dir_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic [0:0]  s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tlast;
    logic [3:0]  m_tuser;

    // walk state of the predictor
    raw_pkg::phase_t wk_phase = raw_pkg::PH_IDLE;
    logic [15:0] wk_pos        = '0;
    logic [15:0] wk_pkt_len    = '0;
    logic [15:0] wk_remain     = '0;
    logic [15:0] wk_attr_start = '0;
    logic [7:0]  wk_type       = '0;
    logic [7:0]  wk_len        = '0;
    logic [7:0]  wk_idx        = '0;
    logic [31:0] wk_vendor     = '0;
    logic [7:0]  wk_inner_type = '0;
    logic [7:0]  wk_inner_len  = '0;

    raw_pkg::res_t report_q[$];
    dir_row_t    dir_tab[$];
    logic [7:0]  pkt_q[$];
    int          n_errors = 0;
    int          cyc_cnt  = 0;
    int          quiet    = 0;
    bit          tx_calm  = 1'b0;
    bit          held_off = 1'b0;

    radius_attribute_walker_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] packet_byte
        .s_tuser  (s_tuser),   // [0] packet_start
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [7:0] attr_type, [39:8] vendor_id,
                               // [55:40] attr_offset, [63:56] attr_length
        .m_tlast  (m_tlast),   // packet_done
        .m_tuser  (m_tuser)    // [0] attr_valid, [3:1] status
    );

    always #5 aclk = ~aclk;

    function automatic int pick_gap(input bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic raw_pkg::res_t walk_fail(input logic [15:0] off,
                                                input raw_pkg::status_t st);
        raw_pkg::res_t r;
        r = '0;
        r.attr_offset = off;
        r.packet_done = 1'b1;
        r.status      = st;
        wk_phase      = raw_pkg::PH_IDLE;
        return r;
    endfunction

    function automatic raw_pkg::res_t walk_complete();
        raw_pkg::res_t r;
        bit   last;
        last = wk_remain < 16'd2;
        r = '0;
        if (wk_type == raw_pkg::VENDOR_SPECIFIC) begin
            r.attr_type   = wk_inner_type;
            r.vendor_id   = wk_vendor;
            r.attr_offset = wk_attr_start + raw_pkg::VSA_INNER_OFFSET;
            r.attr_length = wk_inner_len;
        end else begin
            r.attr_type   = wk_type;
            r.attr_offset = wk_attr_start;
            r.attr_length = wk_len;
        end
        r.attr_valid  = 1'b1;
        r.packet_done = last;
        wk_idx        = '0;
        wk_vendor     = '0;
        wk_inner_type = '0;
        wk_inner_len  = '0;
        if (last) wk_phase = raw_pkg::PH_IDLE;
        return r;
    endfunction

    // one accepted byte through the walk; returns 1 when it yields a report
    function automatic bit walk_byte(input logic [7:0] b, input logic st,
                                     output raw_pkg::res_t r);
        bit         hit;
        bit         vsa;
        logic [7:0] i;
        r   = '0;
        hit = 1'b0;
        if (st) begin
            wk_pos        = '0;
            wk_pkt_len    = '0;
            wk_remain     = '0;
            wk_attr_start = '0;
            wk_type       = '0;
            wk_len        = '0;
            wk_idx        = '0;
            wk_vendor     = '0;
            wk_inner_type = '0;
            wk_inner_len  = '0;
            wk_phase      = raw_pkg::PH_HEADER;
        end
        if (wk_phase == raw_pkg::PH_IDLE) return 1'b0;
        if (wk_phase == raw_pkg::PH_HEADER) begin
            if (wk_pos == raw_pkg::LEN_HI_POS) begin
                wk_pkt_len = {b, 8'h00};
            end else if (wk_pos == raw_pkg::LEN_LO_POS) begin
                wk_pkt_len = wk_pkt_len | {8'h00, b};
                if (wk_pkt_len < raw_pkg::HDR_LEN) begin
                    hit = 1'b1;
                    r   = walk_fail('0, raw_pkg::ST_SHORT_HEADER);
                end
            end else if (wk_pos == raw_pkg::HDR_LAST_POS) begin
                wk_remain = wk_pkt_len - raw_pkg::HDR_LEN;
                if (wk_remain < 16'd2) begin
                    wk_phase      = raw_pkg::PH_IDLE;
                    hit           = 1'b1;
                    r.packet_done = 1'b1;
                end else begin
                    wk_phase = raw_pkg::PH_ATTR;
                    wk_idx   = '0;
                end
            end
        end else begin
            i   = wk_idx;
            vsa = (wk_type == raw_pkg::VENDOR_SPECIFIC);
            if (i == 8'd0) begin
                wk_attr_start = wk_pos;
                wk_type       = b;
                wk_vendor     = '0;
                wk_idx        = 8'd1;
            end else if (i == 8'd1) begin
                hit = 1'b1;
                if ({8'h00, b} > wk_remain) begin
                    r = walk_fail(wk_attr_start, raw_pkg::ST_OVERRUN);
                end else if (b < raw_pkg::ATTR_MIN_LEN) begin
                    r = walk_fail(wk_attr_start, raw_pkg::ST_ATTR_SHORT);
                end else if (vsa && b < raw_pkg::VSA_MIN_LEN) begin
                    r = walk_fail(wk_attr_start, raw_pkg::ST_VSA_SHORT);
                end else begin
                    wk_remain = wk_remain - {8'h00, b};
                    wk_len    = b;
                    wk_idx    = 8'd2;
                    hit       = 1'b0;
                    if (!vsa && b == raw_pkg::ATTR_MIN_LEN) begin
                        hit = 1'b1;
                        r   = walk_complete();
                    end
                end
            end else begin
                if (vsa && i <= 8'd5) begin
                    wk_vendor = {wk_vendor[23:0], b};
                end else if (vsa && i == 8'd6) begin
                    wk_inner_type = b;
                end else if (vsa && i == 8'd7) begin
                    wk_inner_len = b;
                    if (int'(b) + raw_pkg::VSA_HEADER_BYTES != int'(wk_len) + 2) begin
                        hit = 1'b1;
                        r   = walk_fail(wk_attr_start, raw_pkg::ST_VSA_MISMATCH);
                    end
                end
                if (!hit) begin
                    if (int'(i) + 1 >= int'(wk_len)) begin
                        hit = 1'b1;
                        r   = walk_complete();
                    end else begin
                        wk_idx = i + 8'd1;
                    end
                end
            end
        end
        wk_pos = wk_pos + 16'd1;
        return hit;
    endfunction

    task automatic report_mismatch(input string msg);
        if (n_errors < 100) $display("ERROR at %0t: %s", $realtime, msg);
        n_errors++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task automatic add_row(input logic [7:0] b, input logic st, input bit typed,
                           input raw_pkg::res_t r);
        dir_row_t row;
        row.pbyte  = b;
        row.pstart = st;
        row.typed  = typed;
        row.res    = r;
        dir_tab.push_back(row);
    endtask

    task automatic send_item(input logic [7:0] b, input logic st, input bit typed,
                             input raw_pkg::res_t tres);
        int   gap;
        bit   hit;
        raw_pkg::res_t r;
        gap = pick_gap(tx_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= b;
        s_tuser  <= st;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        hit = walk_byte(b, st, r);
        if (typed) report_q.push_back(tres);
        else if (hit) report_q.push_back(r);
    endtask

    // well-formed packet with random content, broken in one place some of the time
    task automatic make_packet();
        int         len_pos[$];
        int         inner_pos[$];
        int         n_attr;
        int         alen;
        int         ilen;
        int         plen;
        int         k;
        logic [7:0] t;
        pkt_q.delete();
        repeat (raw_pkg::HEADER_BYTES) pkt_q.push_back(8'($urandom_range(0, 255)));
        n_attr = $urandom_range(0, 4);
        repeat (n_attr) begin
            if ($urandom_range(0, 3) == 0) begin
                ilen = $urandom_range(2, 6);
                pkt_q.push_back(raw_pkg::VENDOR_SPECIFIC);
                len_pos.push_back(pkt_q.size());
                pkt_q.push_back(8'(ilen + 6));
                repeat (5) pkt_q.push_back(8'($urandom_range(0, 255)));
                inner_pos.push_back(pkt_q.size());
                pkt_q.push_back(8'(ilen));
                repeat (ilen - 2) pkt_q.push_back(8'($urandom_range(0, 255)));
            end else begin
                do t = 8'($urandom_range(0, 255)); while (t == raw_pkg::VENDOR_SPECIFIC);
                alen = $urandom_range(2, 7);
                pkt_q.push_back(t);
                len_pos.push_back(pkt_q.size());
                pkt_q.push_back(8'(alen));
                repeat (alen - 2) pkt_q.push_back(8'($urandom_range(0, 255)));
            end
        end
        plen     = pkt_q.size() + $urandom_range(0, 1);
        pkt_q[2] = 8'(plen >> 8);
        pkt_q[3] = 8'(plen);
        case ($urandom_range(0, 9))
            0: begin
                pkt_q[2] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'h00;
                pkt_q[3] = 8'($urandom_range(0, 255));
            end
            1: begin
                if (len_pos.size() > 0) begin
                    k = $urandom_range(0, len_pos.size() - 1);
                    pkt_q[len_pos[k]] = 8'($urandom_range(0, 255));
                end
            end
            2: begin
                if (inner_pos.size() > 0) begin
                    k = $urandom_range(0, inner_pos.size() - 1);
                    pkt_q[inner_pos[k]] = 8'($urandom_range(0, 255));
                end
            end
            3: begin
                k = $urandom_range(1, pkt_q.size() - 1);
                while (pkt_q.size() > k) void'(pkt_q.pop_back());
            end
            4: begin
                if (len_pos.size() > 0) begin
                    k = $urandom_range(0, len_pos.size() - 1);
                    pkt_q[len_pos[k]] = 8'($urandom_range(0, 7));
                end
            end
            default: ;
        endcase
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) pkt_q.push_back(8'($urandom_range(0, 255)));
    endtask

    initial begin : stim
        raw_pkg::res_t r_short;
        raw_pkg::res_t r_empty;
        int   n_sent;
        r_short             = '0;
        r_short.packet_done = 1'b1;
        r_short.status      = raw_pkg::ST_SHORT_HEADER;
        r_empty             = '0;
        r_empty.packet_done = 1'b1;
        n_sent              = 0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // short header, then a byte after the walk has ended
        add_row(8'hFF, 1'b1, 1'b0, '0);
        add_row(8'hFF, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, '0);
        add_row(8'h13, 1'b0, 1'b1, r_short);
        add_row(8'hFF, 1'b0, 1'b0, '0);
        // walk abandoned by a fresh start, then a header with an empty body
        add_row(8'h00, 1'b1, 1'b0, '0);
        add_row(8'h01, 1'b0, 1'b0, '0);
        add_row(8'hAA, 1'b1, 1'b0, '0);
        add_row(8'h55, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, '0);
        add_row(8'h14, 1'b0, 1'b0, '0);
        for (int p = 4; p < raw_pkg::HEADER_BYTES - 1; p++)
            add_row(p[0] ? 8'hFF : 8'h00, 1'b0, 1'b0, '0);
        add_row(8'hFF, 1'b0, 1'b1, r_empty);

        foreach (dir_tab[i])
            send_item(dir_tab[i].pbyte, dir_tab[i].pstart, dir_tab[i].typed, dir_tab[i].res);

        while (n_sent < RAND_ITEMS) begin
            make_packet();
            tx_calm = ($urandom_range(0, 4) == 0);
            foreach (pkt_q[i]) send_item(pkt_q[i], i == 0, 1'b0, '0);
            n_sent += pkt_q.size();
        end
        s_tvalid <= 1'b0;

        while (report_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (n_errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin : rx_ready
        int gap;
        int run;
        wait (aresetn);
        forever begin
            // one long hold-off so the output slots fill and the input stalls
            if (!held_off && cyc_cnt >= HOLD_AT) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                held_off = 1'b1;
            end
            gap = pick_gap($urandom_range(0, 5) == 0);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            run = $urandom_range(1, 12);
            repeat (run) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin : report_check
        raw_pkg::res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (report_q.size() == 0) begin
                report_mismatch($sformatf("result with none pending: %h", m_tdata));
            end else begin
                want = report_q.pop_front();
                check_field("attr_type",   32'(m_tdata[7:0]),   32'(want.attr_type));
                check_field("vendor_id",   m_tdata[39:8],       want.vendor_id);
                check_field("attr_offset", 32'(m_tdata[55:40]), 32'(want.attr_offset));
                check_field("attr_length", 32'(m_tdata[63:56]), 32'(want.attr_length));
                check_field("attr_valid",  32'(m_tuser[0]),     32'(want.attr_valid));
                check_field("packet_done", 32'(m_tlast),        32'(want.packet_done));
                check_field("status",      32'(m_tuser[3:1]),   32'(want.status));
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if (aresetn) begin
            cyc_cnt++;
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
                if (quiet >= QUIET_LIMIT) begin
                    $display("Mismatches found");
                    $finish;
                end
            end
        end
    end

endmodule
